### design/dadd_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and calendar functions for the date stepper
// no dependencies

package dadd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 16;

  localparam logic [YEAR_W-1:0]  MAX_YEAR   = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR  = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN  = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP  = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV  = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = DAY_W'(31);

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } dadd_date_t;

  // leap year when divisible by four
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                    input logic [YEAR_W-1:0] year);
    logic [DAY_W-1:0] len;
    if (month == MONTH_FEB) begin
      len = (year[1:0] == 2'b00) ? DAY_W'(29) : DAY_W'(28);
    end else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV) begin
      len = DAY_W'(30);
    end else begin
      len = DAY_W'(31);
    end
    return len;
  endfunction

  function automatic logic date_ok(input dadd_date_t d);
    logic ok;
    ok = (d.year <= MAX_YEAR) && (d.month >= MONTH_JAN) && (d.month <= MONTH_DEC) &&
         (d.day >= DAY_FIRST) && (d.day <= month_length(d.month, d.year));
    return ok;
  endfunction

endpackage

### design/dadd_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the request and result words
// depends on dadd_pkg

interface dadd_in_if;
  import dadd_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [DAY_W-1:0]   start_day;
  logic [MONTH_W-1:0] start_month;
  logic [YEAR_W-1:0]  start_year;
  logic [COUNT_W-1:0] day_count;

  modport source (output valid, kind, start_day, start_month, start_year, day_count,
                  input ready);
  modport sink   (input valid, kind, start_day, start_month, start_year, day_count,
                  output ready);
endinterface

interface dadd_out_if;
  import dadd_pkg::*;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   result_day;
  logic [MONTH_W-1:0] result_month;
  logic [YEAR_W-1:0]  result_year;
  logic               result_valid;

  modport source (output valid, result_day, result_month, result_year, result_valid,
                  input ready);
  modport sink   (input valid, result_day, result_month, result_year, result_valid,
                  output ready);
endinterface

### design/date_add_subtract_days_top.sv
`timescale 1ns / 1ps
// date stepper top level: sequencer, count register and result register
// depends on dadd_pkg, dadd_ifs and dadd_day_step
//
//  channel | dir | word
//  --------+-----+-------------------------------------------------------------
//  in_ch   | in  | kind, start_day, start_month, start_year, day_count
//  out_ch  | out | result_day, result_month, result_year, result_valid
//
// an accepted word is stepped one day per cycle through the single-day step unit,
// then the finished date is loaded into the result register once that register is free;
// the input is ready again at the edge that loads the result register
// an invalid start or a step past either end of the year range finishes early
// reset (rst_n low at a clock edge) returns to idle and drops any pending result
// a stalled result holds in the result register; the next word is taken while
// it waits, and the finished date waits in the sequencer until the register frees

module date_add_subtract_days_top (
  input  logic        clk,
  input  logic        rst_n,
  dadd_in_if.sink     in_ch,
  dadd_out_if.source  out_ch
);
  import dadd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t             state_r;
  dadd_date_t         date_r;      // date being stepped
  logic               back_r;      // stepping direction
  logic [COUNT_W-1:0] cnt_r;       // days still to step
  logic               ok_r;        // date still valid
  logic               out_valid_r;
  dadd_date_t         out_date_r;
  logic               out_ok_r;

  dadd_date_t         step_date;
  logic               step_fail;
  dadd_date_t         start_date;
  logic               done;
  logic               out_free;
  logic               load_out;

  dadd_day_step u_step (
    .back (back_r),
    .cur  (date_r),
    .nxt  (step_date),
    .fail (step_fail)
  );

  assign start_date = '{day: in_ch.start_day, month: in_ch.start_month,
                        year: in_ch.start_year};

  // the loop ends when the count runs out or the date has gone invalid
  assign done     = (cnt_r == '0) || !ok_r;
  assign out_free = !out_valid_r || out_ch.ready;
  // finished date moves into the result register
  assign load_out = (state_r == ST_RUN) && done && out_free;

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result word leaves when taken, unless a new one replaces it
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            date_r  <= start_date;
            back_r  <= in_ch.kind;
            cnt_r   <= in_ch.day_count;
            ok_r    <= date_ok(start_date);
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (done) begin
            if (out_free) begin
              out_ok_r    <= ok_r;
              out_date_r  <= ok_r ? date_r : '0;
              state_r     <= ST_IDLE;
            end
          end else begin
            // one day per cycle through the single-day step unit
            if (step_fail) begin
              ok_r <= 1'b0;
            end else begin
              date_r <= step_date;
            end
            cnt_r <= cnt_r - COUNT_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_day   = out_date_r.day;
  assign out_ch.result_month = out_date_r.month;
  assign out_ch.result_year  = out_date_r.year;
  assign out_ch.result_valid = out_ok_r;

endmodule

### design/dadd_day_step.sv
`timescale 1ns / 1ps
// single-day step unit: moves a date one day forward or backward
// depends on dadd_pkg

module dadd_day_step (
  input  logic              back,
  input  dadd_pkg::dadd_date_t cur,
  output dadd_pkg::dadd_date_t nxt,
  output logic              fail
);
  import dadd_pkg::*;

  logic [MONTH_W-1:0] prev_month;

  assign prev_month = cur.month - MONTH_W'(1);

  always_comb begin
    nxt  = cur;
    fail = 1'b0;
    if (!back) begin
      if (cur.day < month_length(cur.month, cur.year)) begin
        nxt.day = cur.day + DAY_W'(1);
      end else if (cur.month < MONTH_DEC) begin
        nxt.day   = DAY_FIRST;
        nxt.month = cur.month + MONTH_W'(1);
      end else if (cur.year < MAX_YEAR) begin
        nxt.day   = DAY_FIRST;
        nxt.month = MONTH_JAN;
        nxt.year  = cur.year + YEAR_W'(1);
      end else begin
        fail = 1'b1;
      end
    end else begin
      if (cur.day > DAY_FIRST) begin
        nxt.day = cur.day - DAY_W'(1);
      end else if (cur.month > MONTH_JAN) begin
        nxt.month = prev_month;
        nxt.day   = month_length(prev_month, cur.year);
      end else if (cur.year != '0) begin
        nxt.year  = cur.year - YEAR_W'(1);
        nxt.month = MONTH_DEC;
        nxt.day   = DAY_LAST_DEC;
      end else begin
        fail = 1'b1;
      end
    end
  end

endmodule

### design/dadd_chk.sv
`timescale 1ns / 1ps
// port-level checker for the date stepper, bound to the top level
// depends on dadd_pkg

module dadd_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dadd_pkg::DAY_W-1:0]   result_day,
  input logic [dadd_pkg::MONTH_W-1:0] result_month,
  input logic [dadd_pkg::YEAR_W-1:0]  result_year,
  input logic                        result_valid
);
  import dadd_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_day) &&
    $stable(result_month) && $stable(result_year) && $stable(result_valid))
    else $error("stalled result changed");

  // invalid result is all zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !result_valid |->
    result_day == '0 && result_month == '0 && result_year == '0)
    else $error("invalid result not zeroed");

  // valid result is in calendar range
  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_valid |->
    result_month >= MONTH_JAN && result_month <= MONTH_DEC &&
    result_day >= DAY_FIRST && result_day <= month_length(result_month, result_year) &&
    result_year <= MAX_YEAR)
    else $error("valid result out of range");

  // busy after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind date_add_subtract_days_top dadd_chk u_dadd_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_day   (out_ch.result_day),
  .result_month (out_ch.result_month),
  .result_year  (out_ch.result_year),
  .result_valid (out_ch.result_valid)
);
